/* rtl/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, widths and helpers for the sprite blitter with clipping,
// horizontal flip and color key.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int CMD_W        = 2;
   localparam int POS_W        = 16;
   localparam int DIM_W        = 13;
   localparam int IDX_W        = 8;
   localparam int COLOUR_W     = 32;
   localparam int COORD_W      = 12;
   localparam int ADDR_W       = 24;
   localparam int ORG_W        = 18;
   localparam int CSR_W        = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int SCREEN_LIMIT = 4096;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);

   // request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_PAL_WRITE = 2'd0,
      CMD_START     = 2'd1,
      CMD_PIXEL     = 2'd2
   } cmd_type;

   // CSR register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_ROW_PITCH     = 2'd2
   } csr_idx_type;

   // clip window, already saturated
   typedef struct packed {
      logic [DIM_W-1:0] screen_width;
      logic [DIM_W-1:0] screen_height;
   } clip_type;

   // one framebuffer write travelling from front to back
   typedef struct packed {
      logic [COORD_W-1:0]  fb_x;
      logic [COORD_W-1:0]  fb_y;
      logic [COLOUR_W-1:0] colour;
      logic                last_pixel;
   } px_op_type;

   // screen size and pitch saturate at the screen limit
   function automatic logic [DIM_W-1:0] sat_screen(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(SCREEN_LIMIT);
      return (v > lim) ? lim : v;
   endfunction

endpackage

/* rtl/sbc_ram.sv */
// ----------------------------------------------------------------------------
// sbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sbc_front.sv */
// ----------------------------------------------------------------------------
// sbc_front
// Accepts requests, keeps palette and sprite raster state, clips and keys
// each pixel, and pushes surviving pixels with their color to the queue.
// ----------------------------------------------------------------------------
module sbc_front #(
   parameter int PALETTE_DEPTH = 256,
   parameter int MAX_DIM       = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sbc_pkg::CMD_W-1:0]             req_cmd,
   input  logic signed [sbc_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [sbc_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [sbc_pkg::POS_W-1:0]      req_axis_x,
   input  logic signed [sbc_pkg::POS_W-1:0]      req_axis_y,
   input  logic [sbc_pkg::DIM_W-1:0]             req_sprite_w,
   input  logic [sbc_pkg::DIM_W-1:0]             req_sprite_h,
   input  logic                                  req_use_mask,
   input  logic                                  req_flip_h,
   input  logic [sbc_pkg::IDX_W-1:0]             req_pal_index,
   input  logic [sbc_pkg::COLOUR_W-1:0]          req_pal_colour,
   input  logic [sbc_pkg::IDX_W-1:0]             req_pixel_index,
   // clip window
   input  sbc_pkg::clip_type                     clip,
   // queue side
   input  logic [sbc_pkg::QLVL_W-1:0]            q_level,
   output logic                                  push_valid,
   output sbc_pkg::px_op_type                    push_data
);
   import sbc_pkg::*;

   localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int XW     = ORG_W + 1;

   typedef struct packed {
      logic [ORG_W-1:0] origin_x;
      logic [ORG_W-1:0] origin_y;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] row;
      logic [IDX_W-1:0] key_index;
      logic             key_seen;
      logic             mask;
      logic             flip;
   } sprite_type;

   typedef struct packed {
      logic [COORD_W-1:0] fb_x;
      logic [COORD_W-1:0] fb_y;
      logic               last_pixel;
      logic               oob;
   } s1_type;

   sprite_type sprite_ff, sprite_in;
   logic       s1_valid_ff, s1_valid_in;
   s1_type     s1_ff, s1_in;

   logic                 accept;
   logic [QLVL_W:0]      in_flight;
   logic                 is_pal, is_start, is_pixel;
   logic [DIM_W-1:0]     w_clamp, h_clamp;
   logic [ORG_W-1:0]     px_e, py_e, ax_e, ay_e, w_e;
   logic [DIM_W-1:0]     col_term, col_inc, row_inc;
   logic [XW-1:0]        dx, dy;
   logic                 active, visible, keyed, survive, last;
   logic                 pal_wr_en, pal_rd_en;
   logic [COLOUR_W-1:0]  pal_rd_data;

   // ready while the queue has room for everything in flight
   assign in_flight = {1'b0, q_level} + {{QLVL_W{1'b0}}, s1_valid_ff};
   assign req_ready = in_flight < (QLVL_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // command decode
   always_comb begin
      is_pal   = 1'b0;
      is_start = 1'b0;
      is_pixel = 1'b0;
      case (cmd_type'(req_cmd))
         CMD_PAL_WRITE: is_pal   = 1'b1;
         CMD_START:     is_start = 1'b1;
         CMD_PIXEL:     is_pixel = 1'b1;
         default:       ;
      endcase
   end

   // sprite start: clamp size, work out origin
   always_comb begin
      if (req_sprite_w == '0) begin
         w_clamp = DIM_W'(1);
      end else if (32'(req_sprite_w) > MAX_DIM) begin
         w_clamp = DIM_W'(MAX_DIM);
      end else begin
         w_clamp = req_sprite_w;
      end
      if (req_sprite_h == '0) begin
         h_clamp = DIM_W'(1);
      end else if (32'(req_sprite_h) > MAX_DIM) begin
         h_clamp = DIM_W'(MAX_DIM);
      end else begin
         h_clamp = req_sprite_h;
      end
   end

   assign px_e = {{(ORG_W - POS_W){req_pos_x[POS_W-1]}}, req_pos_x};
   assign py_e = {{(ORG_W - POS_W){req_pos_y[POS_W-1]}}, req_pos_y};
   assign ax_e = {{(ORG_W - POS_W){req_axis_x[POS_W-1]}}, req_axis_x};
   assign ay_e = {{(ORG_W - POS_W){req_axis_y[POS_W-1]}}, req_axis_y};
   assign w_e  = {{(ORG_W - DIM_W){1'b0}}, w_clamp};

   // pixel: raster position, screen position, clip and key
   assign active   = (sprite_ff.width != '0) && (sprite_ff.row < sprite_ff.height);
   assign col_inc  = sprite_ff.col + DIM_W'(1);
   assign row_inc  = sprite_ff.row + DIM_W'(1);
   assign col_term = sprite_ff.flip ? (sprite_ff.width - col_inc) : sprite_ff.col;
   assign dx = {sprite_ff.origin_x[ORG_W-1], sprite_ff.origin_x}
             + {{(XW - DIM_W){1'b0}}, col_term};
   assign dy = {sprite_ff.origin_y[ORG_W-1], sprite_ff.origin_y}
             + {{(XW - DIM_W){1'b0}}, sprite_ff.row};
   assign visible = !dx[XW-1] && !dy[XW-1]
                 && (dx[XW-2:0] < {{(XW - 1 - DIM_W){1'b0}}, clip.screen_width})
                 && (dy[XW-2:0] < {{(XW - 1 - DIM_W){1'b0}}, clip.screen_height});
   // the first pixel sets the key, so it matches itself
   assign keyed   = sprite_ff.mask
                 && (!sprite_ff.key_seen || (req_pixel_index == sprite_ff.key_index));
   assign last    = (col_inc == sprite_ff.width) && (row_inc == sprite_ff.height);
   assign survive = active && visible && !keyed;

   // sprite state next value
   always_comb begin
      sprite_in = sprite_ff;
      if (accept && is_start) begin
         sprite_in.width     = w_clamp;
         sprite_in.height    = h_clamp;
         sprite_in.mask      = req_use_mask;
         sprite_in.flip      = req_flip_h;
         sprite_in.origin_x  = req_flip_h ? (px_e - (w_e - ax_e)) : (px_e - ax_e);
         sprite_in.origin_y  = py_e - ay_e;
         sprite_in.col       = '0;
         sprite_in.row       = '0;
         sprite_in.key_index = '0;
         sprite_in.key_seen  = 1'b0;
      end else if (accept && is_pixel && active) begin
         if (!sprite_ff.key_seen) begin
            sprite_in.key_index = req_pixel_index;
            sprite_in.key_seen  = 1'b1;
         end
         if (col_inc >= sprite_ff.width) begin
            sprite_in.col = '0;
            sprite_in.row = row_inc;
         end else begin
            sprite_in.col = col_inc;
         end
      end
   end

   // palette read stage
   assign pal_rd_en       = accept && is_pixel && survive;
   assign s1_valid_in     = pal_rd_en;
   assign s1_in.fb_x      = dx[COORD_W-1:0];
   assign s1_in.fb_y      = dy[COORD_W-1:0];
   assign s1_in.last_pixel = last;
   assign s1_in.oob       = 32'(req_pixel_index) >= PALETTE_DEPTH;

   assign pal_wr_en = accept && is_pal && (32'(req_pal_index) < PALETTE_DEPTH);

   sbc_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_pal_index[PAL_AW-1:0]),
      .wr_data (req_pal_colour),
      .rd_en   (pal_rd_en),
      .rd_addr (req_pixel_index[PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         sprite_ff   <= sprite_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_valid_in) begin
         s1_ff <= s1_in;
      end
   end

   // push toward the back end
   assign push_valid           = s1_valid_ff;
   assign push_data.fb_x       = s1_ff.fb_x;
   assign push_data.fb_y       = s1_ff.fb_y;
   assign push_data.last_pixel = s1_ff.last_pixel;
   assign push_data.colour     = s1_ff.oob ? '0 : pal_rd_data;

endmodule

/* rtl/sbc_queue.sv */
// ----------------------------------------------------------------------------
// sbc_queue
// Short FIFO of framebuffer writes between the front and back ends.
// ----------------------------------------------------------------------------
module sbc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  sbc_pkg::px_op_type         push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output sbc_pkg::px_op_type         pop_data,
   output logic [sbc_pkg::QLVL_W-1:0] level
);
   import sbc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   px_op_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]   level_ff, level_in;
   logic                pop;

   // the front only pushes when there is room
   assign pop       = pop_valid && pop_ready;
   assign wr_ptr_in = push_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign level_in  = level_ff + QLVL_W'(push_valid) - QLVL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = level_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

/* rtl/sbc_back.sv */
// ----------------------------------------------------------------------------
// sbc_back
// Takes queued writes, forms the framebuffer address and holds the response
// in an output register.
// ----------------------------------------------------------------------------
module sbc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  sbc_pkg::px_op_type            pop_data,
   input  logic [sbc_pkg::DIM_W-1:0]     row_pitch,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sbc_pkg::COORD_W-1:0]   rsp_fb_x,
   output logic [sbc_pkg::COORD_W-1:0]   rsp_fb_y,
   output logic [sbc_pkg::ADDR_W-1:0]    rsp_fb_address,
   output logic [sbc_pkg::COLOUR_W-1:0]  rsp_colour,
   output logic                          rsp_last_pixel
);
   import sbc_pkg::*;

   localparam int PROD_W = COORD_W + DIM_W;

   logic                 rsp_valid_ff, rsp_valid_in;
   px_op_type            op_ff;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [PROD_W-1:0]    prod;
   logic                 load;

   // output register free or being drained
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   // row times pitch plus column
   assign prod    = PROD_W'(pop_data.fb_y) * PROD_W'(row_pitch);
   assign addr_in = prod[ADDR_W-1:0] + ADDR_W'(pop_data.fb_x);

   assign rsp_valid_in = pop_ready ? pop_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         op_ff   <= pop_data;
         addr_ff <= addr_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fb_x       = op_ff.fb_x;
   assign rsp_fb_y       = op_ff.fb_y;
   assign rsp_fb_address = addr_ff;
   assign rsp_colour     = op_ff.colour;
   assign rsp_last_pixel = op_ff.last_pixel;

endmodule

/* rtl/sprite_blitter_clip_flip_key_top.sv */
// Path: palette read register, queue, response register (address multiply);
// held while the response side stalls. Throughput: one request per cycle
// while the queue has room; a pixel write leaves every cycle while rsp_ready
// is high, bounded by the single palette read port and the one multiplier.
// Reset: clears sprite state, queue and response valid; CSRs return to
// 320 x 240 with pitch 320; palette contents are undefined until written.
// ----------------------------------------------------------------------------
// sprite_blitter_clip_flip_key_top
// Palettized sprite blitter: front end clips and keys pixels, back end forms
// framebuffer writes; a short queue decouples them.
// ----------------------------------------------------------------------------
module sprite_blitter_clip_flip_key_top #(
   parameter int PALETTE_DEPTH = 256,
   parameter int MAX_DIM       = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // CSR write port
   input  logic                                 csr_we,
   input  logic [sbc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sbc_pkg::CSR_W-1:0]            csr_wdata,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sbc_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [sbc_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [sbc_pkg::POS_W-1:0]     req_pos_y,
   input  logic signed [sbc_pkg::POS_W-1:0]     req_axis_x,
   input  logic signed [sbc_pkg::POS_W-1:0]     req_axis_y,
   input  logic [sbc_pkg::DIM_W-1:0]            req_sprite_w,
   input  logic [sbc_pkg::DIM_W-1:0]            req_sprite_h,
   input  logic                                 req_use_mask,
   input  logic                                 req_flip_h,
   input  logic [sbc_pkg::IDX_W-1:0]            req_pal_index,
   input  logic [sbc_pkg::COLOUR_W-1:0]         req_pal_colour,
   input  logic [sbc_pkg::IDX_W-1:0]            req_pixel_index,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sbc_pkg::COORD_W-1:0]          rsp_fb_x,
   output logic [sbc_pkg::COORD_W-1:0]          rsp_fb_y,
   output logic [sbc_pkg::ADDR_W-1:0]           rsp_fb_address,
   output logic [sbc_pkg::COLOUR_W-1:0]         rsp_colour,
   output logic                                 rsp_last_pixel
);
   import sbc_pkg::*;

   logic [CSR_W-1:0]   screen_width_ff, screen_width_in;
   logic [CSR_W-1:0]   screen_height_ff, screen_height_in;
   logic [CSR_W-1:0]   row_pitch_ff, row_pitch_in;
   clip_type           clip;
   logic [DIM_W-1:0]   pitch_sat;
   logic               push_valid;
   px_op_type          push_data;
   logic               pop_valid, pop_ready;
   px_op_type          pop_data;
   logic [QLVL_W-1:0]  q_level;

   // CSR writes
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      row_pitch_in     = row_pitch_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            CSR_ROW_PITCH:     row_pitch_in     = csr_wdata;
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= CSR_W'(320);
         screen_height_ff <= CSR_W'(240);
         row_pitch_ff     <= CSR_W'(320);
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         row_pitch_ff     <= row_pitch_in;
      end
   end

   // saturated views of the CSRs
   assign clip.screen_width  = sat_screen(screen_width_ff);
   assign clip.screen_height = sat_screen(screen_height_ff);
   assign pitch_sat          = sat_screen(row_pitch_ff);

   sbc_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .MAX_DIM       (MAX_DIM)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_axis_x      (req_axis_x),
      .req_axis_y      (req_axis_y),
      .req_sprite_w    (req_sprite_w),
      .req_sprite_h    (req_sprite_h),
      .req_use_mask    (req_use_mask),
      .req_flip_h      (req_flip_h),
      .req_pal_index   (req_pal_index),
      .req_pal_colour  (req_pal_colour),
      .req_pixel_index (req_pixel_index),
      .clip            (clip),
      .q_level         (q_level),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   sbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .level      (q_level)
   );

   sbc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .row_pitch      (pitch_sat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_fb_x       (rsp_fb_x),
      .rsp_fb_y       (rsp_fb_y),
      .rsp_fb_address (rsp_fb_address),
      .rsp_colour     (rsp_colour),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

/* verif/sprite_blitter_clip_flip_key_top_tb.sv */
// ----------------------------------------------------------------------------
// sprite_blitter_clip_flip_key_top_tb
// Self-checking bench for the sprite blitter. A directed burst and a long
// stream of random sprites, palette loads and stray requests are pushed
// through the request port under several screen settings. Each accepted
// request is run through a bench-side copy of the blit rules, and every
// framebuffer write is checked against the oldest predicted write.
// ----------------------------------------------------------------------------
module sprite_blitter_clip_flip_key_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import sbc_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int SPRITE_DIM_MAX = 4096;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   // command code the block must drop
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [POS_W-1:0]    axis_x;
      logic [POS_W-1:0]    axis_y;
      logic [DIM_W-1:0]    sprite_w;
      logic [DIM_W-1:0]    sprite_h;
      logic                use_mask;
      logic                flip_h;
      logic [IDX_W-1:0]    pal_index;
      logic [COLOUR_W-1:0] pal_colour;
      logic [IDX_W-1:0]    pixel_index;
   } blit_req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  fb_x;
      logic [COORD_W-1:0]  fb_y;
      logic [ADDR_W-1:0]   fb_address;
      logic [COLOUR_W-1:0] colour;
      logic                last_pixel;
   } fb_write_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   blit_req_type         req_hold = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COORD_W-1:0]   rsp_fb_x;
   logic [COORD_W-1:0]   rsp_fb_y;
   logic [ADDR_W-1:0]    rsp_fb_address;
   logic [COLOUR_W-1:0]  rsp_colour;
   logic                 rsp_last_pixel;

   // stimulus and expectations
   blit_req_type         pending_reqs[$];
   fb_write_type         fb_writes_due[$];
   bit                   pal_loaded[256];
   logic [IDX_W-1:0]     loaded_list[$];
   int                   stim_count = 0;
   int                   req_done_cnt = 0;
   bit                   req_taken = 1'b0;
   int                   err_count = 0;
   int                   stall_cycles = 0;
   int                   send_idle_pct = 0;
   int                   sink_idle_pct = 0;
   int                   holdoff_mark = 32'h7FFF_FFFF;
   bit                   holdoff_done = 1'b0;
   int                   hold_left = 0;

   // bench copy of the blitter state and CSRs
   logic [COLOUR_W-1:0]  pal_mem[256];
   int                   org_x = 0, org_y = 0;
   int                   spr_w = 0, spr_h = 0;
   int                   col_cnt = 0, row_cnt = 0;
   logic [IDX_W-1:0]     key_idx = '0;
   bit                   key_seen = 1'b0;
   bit                   mask_on = 1'b0, flip_on = 1'b0;
   logic [CSR_W-1:0]     cfg_sw = 13'd320, cfg_sh = 13'd240, cfg_pitch = 13'd320;

   sprite_blitter_clip_flip_key_top u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_hold.cmd),
      .req_pos_x       (req_hold.pos_x),
      .req_pos_y       (req_hold.pos_y),
      .req_axis_x      (req_hold.axis_x),
      .req_axis_y      (req_hold.axis_y),
      .req_sprite_w    (req_hold.sprite_w),
      .req_sprite_h    (req_hold.sprite_h),
      .req_use_mask    (req_hold.use_mask),
      .req_flip_h      (req_hold.flip_h),
      .req_pal_index   (req_hold.pal_index),
      .req_pal_colour  (req_hold.pal_colour),
      .req_pixel_index (req_hold.pixel_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_fb_x        (rsp_fb_x),
      .rsp_fb_y        (rsp_fb_y),
      .rsp_fb_address  (rsp_fb_address),
      .rsp_colour      (rsp_colour),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Blit rules
   // ------------------------------------------------------------------------
   function automatic int size_clamp(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      return (v > SPRITE_DIM_MAX) ? SPRITE_DIM_MAX : int'(v);
   endfunction

   function automatic int screen_clamp(input logic [DIM_W-1:0] v);
      return (v > SCREEN_LIMIT) ? SCREEN_LIMIT : int'(v);
   endfunction

   // update state for one accepted request, queue the write it causes
   task automatic blit_step(input blit_req_type r);
      int col, row, dx, dy;
      bit last, visible, keyed;
      fb_write_type w;
      case (r.cmd)
         CMD_PAL_WRITE: pal_mem[r.pal_index] = r.pal_colour;
         CMD_START: begin
            spr_w = size_clamp(r.sprite_w);
            spr_h = size_clamp(r.sprite_h);
            mask_on = r.use_mask;
            flip_on = r.flip_h;
            if (flip_on) begin
               org_x = int'($signed(r.pos_x)) - (spr_w - int'($signed(r.axis_x)));
            end else begin
               org_x = int'($signed(r.pos_x)) - int'($signed(r.axis_x));
            end
            org_y = int'($signed(r.pos_y)) - int'($signed(r.axis_y));
            col_cnt = 0;
            row_cnt = 0;
            key_idx = '0;
            key_seen = 1'b0;
         end
         CMD_PIXEL: begin
            // no sprite yet, or the current one is complete
            if (spr_w != 0 && row_cnt < spr_h) begin
               if (!key_seen) begin
                  key_idx = r.pixel_index;
                  key_seen = 1'b1;
               end
               col = col_cnt;
               row = row_cnt;
               last = (col + 1 == spr_w) && (row + 1 == spr_h);
               col_cnt++;
               if (col_cnt >= spr_w) begin
                  col_cnt = 0;
                  row_cnt++;
               end
               dx = flip_on ? org_x + (spr_w - 1 - col) : org_x + col;
               dy = org_y + row;
               visible = dx >= 0 && dy >= 0 && dx < screen_clamp(cfg_sw)
                         && dy < screen_clamp(cfg_sh);
               keyed = mask_on && r.pixel_index == key_idx;
               // clipped or keyed pixels still advance the raster
               if (visible && !keyed) begin
                  w.fb_x = dx[COORD_W-1:0];
                  w.fb_y = dy[COORD_W-1:0];
                  w.fb_address = ADDR_W'(dy * screen_clamp(cfg_pitch) + dx);
                  w.colour = pal_mem[r.pixel_index];
                  w.last_pixel = last;
                  fb_writes_due.push_back(w);
               end
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_hold <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response ready, with one long hold-off to back up the block
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!holdoff_done && req_done_cnt >= holdoff_mark) begin
            hold_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check writes, predict accepted requests, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      fb_write_type got, want;
      bit moved;
      moved = 1'b0;
      if (!reset && rsp_valid && rsp_ready) begin
         moved = 1'b1;
         got = {rsp_fb_x, rsp_fb_y, rsp_fb_address, rsp_colour, rsp_last_pixel};
         if (fb_writes_due.size() == 0) begin
            err_count++;
            $display("%0t: unexpected fb write x=%0d y=%0d addr=%h color=%h last=%0d",
                     $time, got.fb_x, got.fb_y, got.fb_address, got.colour,
                     got.last_pixel);
         end else begin
            want = fb_writes_due.pop_front();
            if (got !== want) begin
               err_count++;
               $display("%0t: fb write mismatch, expected x=%0d y=%0d addr=%h color=%h last=%0d",
                        $time, want.fb_x, want.fb_y, want.fb_address, want.colour,
                        want.last_pixel);
               $display("%0t:                      actual x=%0d y=%0d addr=%h color=%h last=%0d",
                        $time, got.fb_x, got.fb_y, got.fb_address, got.colour,
                        got.last_pixel);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         moved = 1'b1;
         blit_step(req_hold);
         req_taken = 1'b1;
         req_done_cnt++;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request builders
   // ------------------------------------------------------------------------
   function automatic logic [IDX_W-1:0] pick_index();
      if (loaded_list.size() == 0) return '0;
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // all fields random; unused fields of a command carry noise
   function automatic blit_req_type rand_req();
      blit_req_type r;
      r.cmd         = CMD_W'($urandom_range(3));
      r.pos_x       = POS_W'($urandom);
      r.pos_y       = POS_W'($urandom);
      r.axis_x      = POS_W'($urandom);
      r.axis_y      = POS_W'($urandom);
      r.sprite_w    = DIM_W'($urandom);
      r.sprite_h    = DIM_W'($urandom);
      r.use_mask    = 1'($urandom);
      r.flip_h      = 1'($urandom);
      r.pal_index   = IDX_W'($urandom);
      r.pal_colour  = $urandom;
      r.pixel_index = pick_index();
      return r;
   endfunction

   function automatic blit_req_type pal_req(input int idx, input logic [31:0] colour);
      blit_req_type r;
      r = rand_req();
      r.cmd = CMD_PAL_WRITE;
      r.pal_index = IDX_W'(idx);
      r.pal_colour = colour;
      return r;
   endfunction

   function automatic blit_req_type start_req(input int px, input int py, input int ax,
                                              input int ay, input int w, input int h,
                                              input bit mask, input bit flip);
      blit_req_type r;
      r = rand_req();
      r.cmd = CMD_START;
      r.pos_x = POS_W'(px);
      r.pos_y = POS_W'(py);
      r.axis_x = POS_W'(ax);
      r.axis_y = POS_W'(ay);
      r.sprite_w = DIM_W'(w);
      r.sprite_h = DIM_W'(h);
      r.use_mask = mask;
      r.flip_h = flip;
      return r;
   endfunction

   function automatic blit_req_type pixel_req(input int idx);
      blit_req_type r;
      r = rand_req();
      r.cmd = CMD_PIXEL;
      r.pixel_index = IDX_W'(idx);
      return r;
   endfunction

   // queue one request; pixels only ever use palette entries already loaded
   task automatic queue_item(input blit_req_type r);
      if (r.cmd == CMD_PAL_WRITE && !pal_loaded[r.pal_index]) begin
         pal_loaded[r.pal_index] = 1'b1;
         loaded_list.push_back(r.pal_index);
      end
      if (r.cmd != CMD_NONE) stim_count++;
      pending_reqs.push_back(r);
   endtask

   // a complete sprite near the screen, now and then cut short or overrun
   task automatic queue_sprite();
      int w, h, sw, sh, n;
      logic [IDX_W-1:0] key;
      w = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      sw = screen_clamp(cfg_sw);
      sh = screen_clamp(cfg_sh);
      queue_item(start_req(int'($urandom_range(0, sw + 16)) - 8,
                           int'($urandom_range(0, sh + 16)) - 8,
                           int'($urandom_range(0, w + 4)) - 2,
                           int'($urandom_range(0, h + 2)) - 1,
                           w, h, $urandom_range(9) < 4, 1'($urandom)));
      key = pick_index();
      n = w * h;
      case ($urandom_range(19))
         0: n = n + 1;
         1: n = $urandom_range(0, n - 1);
         default: ;
      endcase
      repeat (n) queue_item(pixel_req(($urandom_range(9) < 4) ? key : pick_index()));
   endtask

   task automatic queue_random(input int n);
      int target, k;
      blit_req_type r;
      target = stim_count + n;
      while (stim_count < target) begin
         k = $urandom_range(9);
         if (k < 7) begin
            queue_sprite();
         end else if (k < 9) begin
            queue_item(pal_req($urandom_range(255), $urandom));
         end else begin
            // stray request of any kind
            r = rand_req();
            queue_item(r);
         end
      end
   endtask

   task automatic queue_directed();
      blit_req_type r;
      queue_item(pal_req(0, 32'hFFFF_FFFF));
      queue_item(pal_req(255, 32'h0000_0000));
      queue_item(pal_req(1, 32'h1234_5678));
      // pixel before any sprite and an unused command: both dropped
      queue_item(pixel_req(0));
      r = rand_req();
      r.cmd = CMD_NONE;
      queue_item(r);
      // 2x2 sprite in the top-left corner, then one pixel past its end
      queue_item(start_req(0, 0, 0, 0, 2, 2, 1'b0, 1'b0));
      queue_item(pixel_req(255));
      queue_item(pixel_req(0));
      queue_item(pixel_req(1));
      queue_item(pixel_req(255));
      queue_item(pixel_req(0));
      // flipped, keyed 3x1 sprite ending in the bottom-right corner
      queue_item(start_req(319, 239, 1, 0, 3, 1, 1'b1, 1'b1));
      queue_item(pixel_req(1));
      queue_item(pixel_req(255));
      queue_item(pixel_req(0));
      // hangs off the left edge
      queue_item(start_req(-1, 0, 0, 0, 3, 1, 1'b0, 1'b0));
      queue_item(pixel_req(1));
      queue_item(pixel_req(0));
      queue_item(pixel_req(255));
      // extreme positions, oversized width, zero height
      queue_item(start_req(-32768, 32767, 32767, -32768, 8191, 0, 1'b1, 1'b1));
      queue_item(pixel_req(255));
      // zero width, oversized height; only the top rows are sent
      queue_item(start_req(5, 5, 0, 0, 0, 8191, 1'b0, 1'b0));
      queue_item(pixel_req(0));
      queue_item(pixel_req(1));
   endtask

   // ------------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------------
   // all requests taken, all writes seen, pipeline drained
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || fb_writes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      case (idx)
         CSR_SCREEN_WIDTH:  cfg_sw = CSR_W'(value);
         CSR_SCREEN_HEIGHT: cfg_sh = CSR_W'(value);
         CSR_ROW_PITCH:     cfg_pitch = CSR_W'(value);
         default: ;
      endcase
   endtask

   task automatic run_phase(input int sw, input int sh, input int pitch, input int n,
                            input int send_pct, input int sink_pct, input bit holdoff);
      wait_idle();
      write_csr(CSR_SCREEN_WIDTH, sw);
      write_csr(CSR_SCREEN_HEIGHT, sh);
      write_csr(CSR_ROW_PITCH, pitch);
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      send_idle_pct = send_pct;
      sink_idle_pct = sink_pct;
      if (holdoff) holdoff_mark = req_done_cnt + 50;
      queue_random(n);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 36;
      sink_idle_pct = 48;
      queue_directed();

      run_phase(64, 40, 64, 180, 36, 48, 1'b0);
      run_phase(4096, 4096, 4096, 200, 36, 48, 1'b1);
      run_phase(8191, 8191, 8191, 150, 48, 36, 1'b0);
      run_phase(0, 0, 0, 40, 48, 36, 1'b0);
      run_phase(1, 1, 1, 40, 48, 36, 1'b0);
      run_phase($urandom_range(1, 400), $urandom_range(1, 300), $urandom_range(400, 600),
                250, 0, 0, 1'b0);
      run_phase(320, 240, 320, 250, 0, 0, 1'b0);

      wait_idle();
      if (err_count == 0 && fb_writes_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
